/* rtl/kfbi_pkg.sv */
`default_nettype none
package kfbi_pkg;

	// fixed wait between the sync byte and the first key byte, in ms ticks
	localparam int unsigned KEY_DELAY_MS = 5;

	localparam int unsigned CFG_DATA_W = 12;
	localparam int unsigned TIMER_W    = 12;

	// address bits plus start and stop bit
	localparam logic [3:0] FRAME_BITS = 4'd10;
	localparam logic [3:0] STOP_IDX   = 4'd9;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_BYTE  = 2'd2
	} req_code_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_IDLE_HIGH  = 4'd1,
		PH_BITS       = 4'd2,
		PH_SYNC_DELAY = 4'd3,
		PH_WAIT_SYNC  = 4'd4,
		PH_KEY_DELAY  = 4'd5,
		PH_WAIT_K1    = 4'd6,
		PH_WAIT_K2    = 4'd7,
		PH_COMP_DELAY = 4'd8,
		PH_WAIT_ECHO  = 4'd9,
		PH_WAIT_ADDR  = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_BUSY     = 3'd1,
		ST_OK       = 3'd2,
		ST_TIMEOUT  = 3'd3,
		ST_MISMATCH = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CFG_INIT_ADDRESS     = 3'd0,
		CFG_BIT_TIME         = 3'd1,
		CFG_IDLE_TIME        = 3'd2,
		CFG_SYNC_DELAY       = 3'd3,
		CFG_SYNC_TIMEOUT     = 3'd4,
		CFG_KEY_TIMEOUT      = 3'd5,
		CFG_COMPLEMENT_DELAY = 3'd6,
		CFG_RESPONSE_TIMEOUT = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} req_item_t;

	typedef struct packed {
		logic       line_level;
		logic       send_strobe;
		logic [7:0] send_byte;
		logic [2:0] status;
		logic [7:0] address_byte;
		logic [7:0] first_key;
		logic [7:0] second_key;
	} res_item_t;

	typedef struct packed {
		logic [2:0]            index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [7:0]  init_address;
		logic [9:0]  bit_time_ms;
		logic [11:0] idle_time_ms;
		logic [9:0]  sync_delay_ms;
		logic [9:0]  sync_timeout_ms;
		logic [9:0]  key_timeout_ms;
		logic [9:0]  complement_delay_ms;
		logic [9:0]  response_timeout_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		init_address:        8'd136,
		bit_time_ms:         10'd200,
		idle_time_ms:        12'd1500,
		sync_delay_ms:       10'd60,
		sync_timeout_ms:     10'd300,
		key_timeout_ms:      10'd20,
		complement_delay_ms: 10'd25,
		response_timeout_ms: 10'd50
	};

endpackage
`default_nettype wire

/* rtl/kfbi_if.sv */
`default_nettype none
interface kfbi_req_if ();
	logic                 valid;
	logic                 ready;
	kfbi_pkg::req_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface kfbi_res_if ();
	logic                 valid;
	logic                 ready;
	kfbi_pkg::res_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface kfbi_cfg_if ();
	logic                 valid;
	logic                 ready;
	kfbi_pkg::cfg_wr_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/kfbi_cfg_regs.sv */
`default_nettype none
module kfbi_cfg_regs (
	input  wire            clk,
	input  wire            arst_n,
	kfbi_cfg_if.sink       cfg,
	output kfbi_pkg::cfg_t regs
);

	kfbi_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= kfbi_pkg::CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (kfbi_pkg::cfg_idx_t'(cfg.payload.index))
				kfbi_pkg::CFG_INIT_ADDRESS:
					regs_q.init_address <= cfg.payload.data[7:0];
				kfbi_pkg::CFG_BIT_TIME:
					regs_q.bit_time_ms <= cfg.payload.data[9:0];
				kfbi_pkg::CFG_IDLE_TIME:
					regs_q.idle_time_ms <= cfg.payload.data[11:0];
				kfbi_pkg::CFG_SYNC_DELAY:
					regs_q.sync_delay_ms <= cfg.payload.data[9:0];
				kfbi_pkg::CFG_SYNC_TIMEOUT:
					regs_q.sync_timeout_ms <= cfg.payload.data[9:0];
				kfbi_pkg::CFG_KEY_TIMEOUT:
					regs_q.key_timeout_ms <= cfg.payload.data[9:0];
				kfbi_pkg::CFG_COMPLEMENT_DELAY:
					regs_q.complement_delay_ms <= cfg.payload.data[9:0];
				kfbi_pkg::CFG_RESPONSE_TIMEOUT:
					regs_q.response_timeout_ms <= cfg.payload.data[9:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/kfbi_seq.sv */
`default_nettype none
module kfbi_seq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  advance,
	input  kfbi_pkg::req_item_t  item,
	input  kfbi_pkg::cfg_t       regs,
	output kfbi_pkg::res_item_t  result
);

	kfbi_pkg::phase_t                  phase_q, phase_n;
	kfbi_pkg::status_t                 status_q, status_n;
	logic [kfbi_pkg::TIMER_W-1:0]      timer_q, timer_n, timer_inc, limit;
	logic [3:0]                        bit_idx_q, bit_idx_n, bit_idx_inc;
	logic [7:0]                        key_one_q, key_one_n;
	logic [7:0]                        key_two_q, key_two_n;
	logic [7:0]                        echo_q, echo_n;
	logic [7:0]                        final_q, final_n;
	logic                              line_q, line_n;
	logic                              strobe;
	logic                              tick_done;

	function automatic logic bit_level(input logic [3:0] idx, input logic [7:0] addr);
		logic lvl;
		if (idx == 4'd0) begin
			lvl = 1'b0;
		end else if (idx >= kfbi_pkg::STOP_IDX) begin
			lvl = 1'b1;
		end else begin
			lvl = addr[3'(idx - 4'd1)];
		end
		return lvl;
	endfunction

	// duration of the current phase
	always_comb begin
		unique case (phase_q)
			kfbi_pkg::PH_IDLE_HIGH:  limit = regs.idle_time_ms;
			kfbi_pkg::PH_BITS:       limit = {2'b00, regs.bit_time_ms};
			kfbi_pkg::PH_SYNC_DELAY: limit = {2'b00, regs.sync_delay_ms};
			kfbi_pkg::PH_WAIT_SYNC:  limit = {2'b00, regs.sync_timeout_ms};
			kfbi_pkg::PH_KEY_DELAY:  limit = kfbi_pkg::TIMER_W'(kfbi_pkg::KEY_DELAY_MS);
			kfbi_pkg::PH_WAIT_K1,
			kfbi_pkg::PH_WAIT_K2:    limit = {2'b00, regs.key_timeout_ms};
			kfbi_pkg::PH_COMP_DELAY: limit = {2'b00, regs.complement_delay_ms};
			kfbi_pkg::PH_WAIT_ECHO,
			kfbi_pkg::PH_WAIT_ADDR:  limit = {2'b00, regs.response_timeout_ms};
			default:                 limit = '0;
		endcase
	end

	// a wrap to zero also ends the wait, and a zero limit acts as one
	assign timer_inc   = timer_q + kfbi_pkg::TIMER_W'(1);
	assign tick_done   = (timer_inc >= limit) || (timer_inc == '0);
	assign bit_idx_inc = bit_idx_q + 4'd1;

	// next state
	always_comb begin
		phase_n   = phase_q;
		status_n  = status_q;
		timer_n   = timer_q;
		bit_idx_n = bit_idx_q;
		key_one_n = key_one_q;
		key_two_n = key_two_q;
		echo_n    = echo_q;
		final_n   = final_q;
		line_n    = line_q;
		unique case (kfbi_pkg::req_code_t'(item.req_type))
			kfbi_pkg::REQ_START: begin
				key_one_n = '0;
				key_two_n = '0;
				echo_n    = '0;
				final_n   = '0;
				bit_idx_n = '0;
				line_n    = 1'b1;
				status_n  = kfbi_pkg::ST_BUSY;
				phase_n   = kfbi_pkg::PH_IDLE_HIGH;
				timer_n   = '0;
			end
			kfbi_pkg::REQ_TICK: begin
				if (phase_q != kfbi_pkg::PH_IDLE) begin
					timer_n = timer_inc;
					if (tick_done) begin
						timer_n = '0;
						unique case (phase_q)
							kfbi_pkg::PH_IDLE_HIGH: begin
								phase_n   = kfbi_pkg::PH_BITS;
								bit_idx_n = '0;
								line_n    = 1'b0;
							end
							kfbi_pkg::PH_BITS: begin
								bit_idx_n = bit_idx_inc;
								if (bit_idx_inc >= kfbi_pkg::FRAME_BITS) begin
									line_n  = 1'b1;
									phase_n = kfbi_pkg::PH_SYNC_DELAY;
								end else begin
									line_n = bit_level(bit_idx_inc, regs.init_address);
								end
							end
							kfbi_pkg::PH_SYNC_DELAY: phase_n = kfbi_pkg::PH_WAIT_SYNC;
							kfbi_pkg::PH_KEY_DELAY:  phase_n = kfbi_pkg::PH_WAIT_K1;
							kfbi_pkg::PH_COMP_DELAY: phase_n = kfbi_pkg::PH_WAIT_ECHO;
							default: begin
								// every remaining phase waits for a byte: give up
								status_n = kfbi_pkg::ST_TIMEOUT;
								line_n   = 1'b1;
								phase_n  = kfbi_pkg::PH_IDLE;
							end
						endcase
					end
				end
			end
			kfbi_pkg::REQ_BYTE: begin
				unique case (phase_q)
					kfbi_pkg::PH_WAIT_SYNC: begin
						phase_n = kfbi_pkg::PH_KEY_DELAY;
						timer_n = '0;
					end
					kfbi_pkg::PH_WAIT_K1: begin
						key_one_n = item.rx_byte;
						phase_n   = kfbi_pkg::PH_WAIT_K2;
						timer_n   = '0;
					end
					kfbi_pkg::PH_WAIT_K2: begin
						key_two_n = item.rx_byte;
						echo_n    = ~item.rx_byte;
						phase_n   = kfbi_pkg::PH_COMP_DELAY;
						timer_n   = '0;
					end
					kfbi_pkg::PH_COMP_DELAY,
					kfbi_pkg::PH_WAIT_ECHO: begin
						timer_n = '0;
						if (item.rx_byte == echo_q) begin
							phase_n = kfbi_pkg::PH_WAIT_ADDR;
						end else begin
							status_n = kfbi_pkg::ST_MISMATCH;
							line_n   = 1'b1;
							phase_n  = kfbi_pkg::PH_IDLE;
						end
					end
					kfbi_pkg::PH_WAIT_ADDR: begin
						final_n  = item.rx_byte;
						status_n = kfbi_pkg::ST_OK;
						line_n   = 1'b1;
						phase_n  = kfbi_pkg::PH_IDLE;
						timer_n  = '0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// outputs: the complement goes out when the delay ends or a byte cuts it short
	always_comb begin
		strobe = 1'b0;
		if (phase_q == kfbi_pkg::PH_COMP_DELAY) begin
			unique case (kfbi_pkg::req_code_t'(item.req_type))
				kfbi_pkg::REQ_TICK: strobe = tick_done;
				kfbi_pkg::REQ_BYTE: strobe = 1'b1;
				default:            strobe = 1'b0;
			endcase
		end
		result.line_level   = line_n;
		result.send_strobe  = strobe;
		result.send_byte    = strobe ? echo_n : 8'h00;
		result.status       = status_n;
		result.address_byte = final_n;
		result.first_key    = key_one_n;
		result.second_key   = key_two_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= kfbi_pkg::PH_IDLE;
			status_q  <= kfbi_pkg::ST_IDLE;
			timer_q   <= '0;
			bit_idx_q <= '0;
			key_one_q <= '0;
			key_two_q <= '0;
			echo_q    <= '0;
			final_q   <= '0;
			line_q    <= 1'b1;
		end else if (advance) begin
			phase_q   <= phase_n;
			status_q  <= status_n;
			timer_q   <= timer_n;
			bit_idx_q <= bit_idx_n;
			key_one_q <= key_one_n;
			key_two_q <= key_two_n;
			echo_q    <= echo_n;
			final_q   <= final_n;
			line_q    <= line_n;
		end
	end

endmodule
`default_nettype wire

/* rtl/kfbi_res_reg.sv */
`default_nettype none
module kfbi_res_reg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  kfbi_pkg::res_item_t  result,
	output logic                 free,
	kfbi_res_if.source           res
);

	logic                 valid_q;
	kfbi_pkg::res_item_t  payload_q;

	assign free        = !valid_q || res.ready;
	assign res.valid   = valid_q;
	assign res.payload = payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			payload_q <= result;
		end
	end

endmodule
`default_nettype wire

/* rtl/kline_five_baud_init.sv */
`default_nettype none
// Tester side of the K-line five baud wakeup. Each transaction on req is a
// start command, a 1 ms tick or a received UART byte, and each one yields
// exactly one transaction on res with the transmit line level, a send strobe
// with the complement byte, the status and the bytes collected so far. An
// item passes through an input register and then a single state update into
// the result register, so one item is taken per clock and its result is
// presented on res by that result register; the only stall comes from res
// backpressure. All times count ticks, not clocks. Write cfg only while
// no req transaction is in flight; a new value takes effect at once, even in
// the middle of a sequence.
module kline_five_baud_init (
	input  wire         clk,
	input  wire         arst_n,
	kfbi_req_if.sink    req,
	kfbi_res_if.source  res,
	kfbi_cfg_if.sink    cfg
);

	logic                 valid_s1;
	kfbi_pkg::req_item_t  item_s1;
	logic                 out_free;
	logic                 advance;
	kfbi_pkg::cfg_t       regs;
	kfbi_pkg::res_item_t  result;

	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
	end

	kfbi_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	kfbi_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.regs    (regs),
		.result  (result)
	);

	kfbi_res_reg u_res_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.result (result),
		.free   (out_free),
		.res    (res)
	);

endmodule
`default_nettype wire
